/* rtl/assert_macros.svh */
// Assertion macros shared by the I2C register-access master RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is active.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_RST(label, clk, rst_n, !(expr), msg)

`endif

/* rtl/i2cram_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the I2C register-access master.
// No dependencies; all RTL files but assert_macros.svh refer to it by scoped names.
package i2cram_pkg;

    // Field widths fixed by the slot format
    localparam int ADDR_W  = 8;
    localparam int COUNT_W = 9;

    // Operation codes carried on each input slot
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input slot
    typedef struct packed {
        logic [1:0]         operation;
        logic [ADDR_W-1:0]  device_address;
        logic [ADDR_W-1:0]  register_address;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         write_byte;
        logic               sda_sample;
    } t_in_item;

    // One result slot
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       byte_request;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy_res;
        logic       done_res;
        logic       success;
    } t_out_item;

    // Classified slot as it travels through the queue
    typedef struct packed {
        logic               start;
        logic               is_read;
        logic [ADDR_W-1:0]  device_address;
        logic [ADDR_W-1:0]  register_address;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         write_byte;
        logic               sda_sample;
    } t_cmd;

endpackage

/* rtl/i2cram_front.sv */
`timescale 1ns / 1ps
// Front stage: accepts input slots, decodes the operation and clips the byte count.
// Depends on i2cram_pkg.
module i2cram_front #(
    parameter int MAX_BYTES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  i2cram_pkg::t_in_item i_in_item,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output i2cram_pkg::t_cmd     o_cmd
);

    localparam logic [31:0] MAX32 = 32'(MAX_BYTES);

    logic             r_valid;
    i2cram_pkg::t_cmd r_cmd;
    i2cram_pkg::t_cmd n_cmd;
    logic             over;

    // Classify the incoming slot
    always_comb begin
        over                   = 32'(i_in_item.byte_count) > MAX32;
        n_cmd.start            = (i_in_item.operation == i2cram_pkg::OP_WRITE) ||
                                 (i_in_item.operation == i2cram_pkg::OP_READ);
        n_cmd.is_read          = (i_in_item.operation == i2cram_pkg::OP_READ);
        n_cmd.device_address   = i_in_item.device_address;
        n_cmd.register_address = i_in_item.register_address;
        n_cmd.byte_count       = over ? i2cram_pkg::COUNT_W'(MAX_BYTES)
                                      : i_in_item.byte_count;
        n_cmd.write_byte       = i_in_item.write_byte;
        n_cmd.sda_sample       = i_in_item.sda_sample;
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Hold one classified beat until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* rtl/i2cram_queue.sv */
`timescale 1ns / 1ps
// Short FIFO between the front and the slot sequencer.
// Depends on i2cram_pkg for the entry type and depth.
module i2cram_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  i2cram_pkg::t_cmd i_push_cmd,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output i2cram_pkg::t_cmd o_pop_cmd
);

    localparam int PW = i2cram_pkg::QPTR_W;
    localparam int CW = i2cram_pkg::QCNT_W;

    i2cram_pkg::t_cmd r_mem [i2cram_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CW'(i2cram_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= PW'(r_wr + 1'b1);
            end
            if (pop) begin
                r_rd <= PW'(r_rd + 1'b1);
            end
            if (push && !pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

/* rtl/i2cram_back.sv */
`timescale 1ns / 1ps
// Slot sequencer: walks the START/byte/ACK/STOP waveforms one slot per beat.
// Depends on i2cram_pkg and assert_macros.svh.
`include "assert_macros.svh"
module i2cram_back #(
    parameter int MAX_BYTES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  i2cram_pkg::t_cmd      i_cmd,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cram_pkg::t_out_item o_out_item
);

    localparam int LW = $clog2(MAX_BYTES + 1);
    localparam int AW = i2cram_pkg::ADDR_W;
    localparam logic [AW-1:0] ADDR_DIR_MASK = 8'hFE;
    localparam logic [AW-1:0] ADDR_DIR_READ = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_FIRST,
        PH_START_AGAIN,
        PH_SEND_ADDR_W,
        PH_SEND_REG,
        PH_SEND_ADDR_R,
        PH_SEND_DATA,
        PH_RECV,
        PH_STOP_OK,
        PH_STOP_FAIL
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [2:0]            r_slot, n_slot;
    logic [3:0]            r_bitc, n_bitc;
    logic [7:0]            r_shift, n_shift;
    logic [LW-1:0]         r_left, n_left;
    logic [AW-1:0]         r_dev, n_dev;
    logic [AW-1:0]         r_reg_addr, n_reg_addr;
    logic                  r_is_read, n_is_read;
    logic                  r_scl, r_sda;
    logic                  r_out_valid;
    i2cram_pkg::t_out_item r_out, n_out;
    t_phase                cur_ph;
    logic                  step;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign step        = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Work out the next sequencer state and the levels of this slot
    always_comb begin
        n_phase    = r_phase;
        n_slot     = r_slot;
        n_bitc     = r_bitc;
        n_shift    = r_shift;
        n_left     = r_left;
        n_dev      = r_dev;
        n_reg_addr = r_reg_addr;
        n_is_read  = r_is_read;
        n_out              = '0;
        n_out.scl_level    = r_scl;
        n_out.sda_level    = r_sda;
        n_out.busy_res     = 1'b1;

        // Latch a new transaction on an idle slot
        if (r_phase == PH_IDLE) begin
            if (i_cmd.start) begin
                n_dev      = i_cmd.device_address;
                n_reg_addr = i_cmd.register_address;
                n_is_read  = i_cmd.is_read;
                n_left     = LW'(i_cmd.byte_count);
                n_phase    = PH_START_FIRST;
                n_slot     = '0;
                n_bitc     = '0;
                n_shift    = '0;
            end else begin
                n_out.busy_res = 1'b0;
            end
        end
        cur_ph = n_phase;

        case (cur_ph)
            PH_IDLE: begin
            end
            PH_START_FIRST, PH_START_AGAIN: begin
                if (n_slot == 3'd1) begin
                    n_out.scl_level = 1'b1;
                    n_out.sda_level = 1'b1;
                end else if (n_slot == 3'd2) begin
                    n_out.sda_level = 1'b0;
                end
                if (n_slot >= 3'd3) begin
                    n_slot = '0;
                    n_bitc = '0;
                    if (cur_ph == PH_START_FIRST) begin
                        n_phase = PH_SEND_ADDR_W;
                        n_shift = n_dev & ADDR_DIR_MASK;
                    end else begin
                        n_phase = PH_SEND_ADDR_R;
                        n_shift = n_dev | ADDR_DIR_READ;
                    end
                end else begin
                    n_slot = 3'(n_slot + 1'b1);
                end
            end
            PH_SEND_ADDR_W, PH_SEND_REG, PH_SEND_ADDR_R, PH_SEND_DATA: begin
                // Load the data byte on the first slot of a data byte
                if (cur_ph == PH_SEND_DATA && n_bitc == 4'd0 && n_slot == 3'd0) begin
                    n_shift = i_cmd.write_byte;
                    if (n_left != '0) begin
                        n_left = LW'(n_left - 1'b1);
                    end
                end
                if (n_bitc < 4'd8) begin
                    if (n_slot == 3'd0) begin
                        n_out.scl_level = 1'b0;
                    end else if (n_slot == 3'd1) begin
                        n_out.sda_level = n_shift[7];
                    end else if (n_slot == 3'd2) begin
                        n_out.scl_level = 1'b1;
                    end
                    if (n_slot >= 3'd3) begin
                        n_shift = {n_shift[6:0], 1'b0};
                        n_bitc  = 4'(n_bitc + 1'b1);
                        n_slot  = '0;
                    end else begin
                        n_slot = 3'(n_slot + 1'b1);
                    end
                end else begin
                    // Acknowledge of a sent byte
                    if (n_slot == 3'd0) begin
                        n_out.scl_level = 1'b0;
                        n_slot = 3'(n_slot + 1'b1);
                    end else if (n_slot == 3'd1) begin
                        n_out.sda_level = 1'b1;
                        n_slot = 3'(n_slot + 1'b1);
                    end else if (n_slot == 3'd2) begin
                        n_out.scl_level = 1'b1;
                        if (i_cmd.sda_sample) begin
                            n_phase = PH_STOP_FAIL;
                            n_slot  = '0;
                            n_bitc  = '0;
                            n_shift = '0;
                        end else begin
                            n_slot = 3'(n_slot + 1'b1);
                        end
                    end else if (n_slot == 3'd3) begin
                        n_slot = 3'(n_slot + 1'b1);
                    end else begin
                        // Pick what follows an acknowledged byte
                        n_out.scl_level = 1'b0;
                        n_slot  = '0;
                        n_bitc  = '0;
                        n_shift = '0;
                        if (cur_ph == PH_SEND_ADDR_W) begin
                            n_phase = PH_SEND_REG;
                            n_shift = n_reg_addr;
                        end else if (cur_ph == PH_SEND_REG && n_is_read) begin
                            n_phase = PH_START_AGAIN;
                        end else if (cur_ph == PH_SEND_ADDR_R) begin
                            n_phase = (n_left != '0) ? PH_RECV : PH_STOP_OK;
                        end else if (n_left != '0) begin
                            n_phase            = PH_SEND_DATA;
                            n_out.byte_request = 1'b1;
                        end else begin
                            n_phase = PH_STOP_OK;
                        end
                    end
                end
            end
            PH_RECV: begin
                if (n_bitc < 4'd8) begin
                    if (n_slot == 3'd0) begin
                        n_out.scl_level = 1'b0;
                        n_out.sda_level = 1'b1;
                    end else if (n_slot == 3'd1) begin
                        n_out.scl_level = 1'b1;
                        n_shift = {n_shift[6:0], i_cmd.sda_sample};
                        if (n_bitc == 4'd7) begin
                            n_out.read_valid = 1'b1;
                            n_out.read_byte  = n_shift;
                        end
                    end else if (n_slot == 3'd3) begin
                        n_out.scl_level = 1'b0;
                    end
                    if (n_slot >= 3'd3) begin
                        n_bitc = 4'(n_bitc + 1'b1);
                        n_slot = '0;
                    end else begin
                        n_slot = 3'(n_slot + 1'b1);
                    end
                end else begin
                    // Answer ACK, or NACK on the last byte
                    if (n_slot == 3'd0) begin
                        n_out.scl_level = 1'b0;
                        n_out.sda_level = (n_left <= LW'(1));
                    end else if (n_slot == 3'd1) begin
                        n_out.scl_level = 1'b1;
                    end else if (n_slot == 3'd3) begin
                        n_out.scl_level = 1'b0;
                    end
                    if (n_slot >= 3'd3) begin
                        if (n_left != '0) begin
                            n_left = LW'(n_left - 1'b1);
                        end
                        n_phase = (n_left != '0) ? PH_RECV : PH_STOP_OK;
                        n_slot  = '0;
                        n_bitc  = '0;
                        n_shift = '0;
                    end else begin
                        n_slot = 3'(n_slot + 1'b1);
                    end
                end
            end
            PH_STOP_OK, PH_STOP_FAIL: begin
                if (n_slot == 3'd0) begin
                    n_out.scl_level = 1'b0;
                    n_out.sda_level = 1'b0;
                end else if (n_slot == 3'd1) begin
                    n_out.scl_level = 1'b1;
                end else if (n_slot == 3'd4) begin
                    n_out.sda_level = 1'b1;
                end
                if (n_slot >= 3'd5) begin
                    n_out.done_res = 1'b1;
                    n_out.success  = (cur_ph == PH_STOP_OK);
                    n_phase = PH_IDLE;
                    n_slot  = '0;
                    n_bitc  = '0;
                    n_shift = '0;
                end else begin
                    n_slot = 3'(n_slot + 1'b1);
                end
            end
            default: begin
                n_phase        = PH_IDLE;
                n_slot         = '0;
                n_bitc         = '0;
                n_shift        = '0;
                n_out.busy_res = 1'b0;
            end
        endcase
    end

    // Hold sequencer state and the registered result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_slot      <= '0;
            r_bitc      <= '0;
            r_shift     <= '0;
            r_left      <= '0;
            r_dev       <= '0;
            r_reg_addr  <= '0;
            r_is_read   <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
            if (step) begin
                r_phase    <= n_phase;
                r_slot     <= n_slot;
                r_bitc     <= n_bitc;
                r_shift    <= n_shift;
                r_left     <= n_left;
                r_dev      <= n_dev;
                r_reg_addr <= n_reg_addr;
                r_is_read  <= n_is_read;
                r_scl      <= n_out.scl_level;
                r_sda      <= n_out.sda_level;
            end
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    `ASSERT_RST(a_rvalid_in_recv, i_clk, i_rst_n, (step && n_out.read_valid) |-> (r_phase == PH_RECV), "read byte outside receive phase")
    `ASSERT_RST(a_done_to_idle, i_clk, i_rst_n, (step && n_out.done_res) |=> (r_phase == PH_IDLE), "transaction end did not return to idle")
    `ASSERT_RST(a_req_to_data, i_clk, i_rst_n, (step && n_out.byte_request) |=> (r_phase == PH_SEND_DATA && r_slot == 3'd0 && r_bitc == 4'd0), "byte request without data phase")
    `ASSERT_NEVER(a_no_pop_on_stall, i_clk, i_rst_n, r_out_valid && !i_out_ready && o_cmd_ready, "beat taken while result stalled")

endmodule

/* rtl/i2c_register_access_master_core.sv */
`timescale 1ns / 1ps
// Top level of the I2C register-access master: front stage, queue and slot sequencer.
// Depends on i2cram_pkg, i2cram_front, i2cram_queue and i2cram_back.
//
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------
// in       | input     | i_in_valid / o_in_ready | i_in_item (t_in_item)
// out      | output    | o_out_valid/i_out_ready | o_out_item (t_out_item)
//
// Every accepted slot gives one result beat; one slot per clock while out is not stalled.
// A slot passes three registers: front stage, queue entry, sequencer output register.
// Its result register loads once the slot has passed the front stage and the queue entry;
// the sequencer step between queue and result register is combinational.
// Reset is synchronous and active low; the bus lines come out of reset released high.
// A stalled output holds the sequencer; the queue of four entries absorbs slots meanwhile.
module i2c_register_access_master_core #(
    parameter int MAX_BYTES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cram_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cram_pkg::t_out_item o_out_item
);

    logic             f_valid;
    logic             f_ready;
    i2cram_pkg::t_cmd f_cmd;
    logic             q_valid;
    logic             q_ready;
    i2cram_pkg::t_cmd q_cmd;

    // Decode and clip incoming slots
    i2cram_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    // Decouple front from sequencer
    i2cram_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    // Drive the bus waveform one slot per beat
    i2cram_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* tb/i2c_register_access_master_core_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for i2c_register_access_master_core: drives bus slots, predicts
// every result beat in a local slot sequencer and compares them. Uses i2cram_pkg types.
module i2c_register_access_master_core_test;

    localparam int          BYTE_LIMIT  = 256;
    localparam int          QUIET_LIMIT = 1000;
    localparam int          SETTLE      = 16;
    localparam logic [1:0]  OP_SPARE    = 2'd3;

    // Sequencer phases of the local slot model
    typedef enum logic [3:0] {
        BUS_IDLE, BUS_START, BUS_RESTART, SEND_DEV_W, SEND_REG, SEND_DEV_R,
        SEND_DATA, RECV_DATA, STOP_OK, STOP_FAIL
    } t_bus_phase;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    i2cram_pkg::t_in_item  in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    i2cram_pkg::t_out_item out_item;

    // Model state of the slot sequencer
    t_bus_phase  bus_phase = BUS_IDLE;
    int unsigned slot_cnt = 0;
    int unsigned bit_cnt = 0;
    logic [7:0]  shifter = 8'h00;
    int unsigned bytes_remaining = 0;
    logic [7:0]  dev_addr = 8'h00;
    logic [7:0]  reg_addr = 8'h00;
    logic        rd_dir = 1'b0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;

    i2cram_pkg::t_out_item slots_due[$];
    int feed_idle_pct = 0;
    int drain_idle_pct = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int slots_sent = 0;
    int results_seen = 0;
    int transfers_started = 0;
    int transfers_ok = 0;
    int transfers_nacked = 0;
    int bytes_fed = 0;
    int bytes_read = 0;

    i2c_register_access_master_core #(
        .MAX_BYTES(BYTE_LIMIT)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Load a phase and clear its counters
    function automatic void goto_phase(input t_bus_phase ph, input logic [7:0] value);
        bus_phase = ph;
        slot_cnt  = 0;
        bit_cnt   = 0;
        shifter   = value;
    endfunction

    // Pick what follows an acknowledged byte; return 1 when a write byte is wanted
    function automatic logic pick_after_ack();
        case (bus_phase)
            SEND_DEV_W: begin
                goto_phase(SEND_REG, reg_addr);
                return 1'b0;
            end
            SEND_REG: begin
                if (rd_dir) begin
                    goto_phase(BUS_RESTART, 8'h00);
                    return 1'b0;
                end
            end
            SEND_DEV_R: begin
                if (bytes_remaining > 0) goto_phase(RECV_DATA, 8'h00);
                else goto_phase(STOP_OK, 8'h00);
                return 1'b0;
            end
            default: ;
        endcase
        if (bytes_remaining > 0) begin
            goto_phase(SEND_DATA, 8'h00);
            return 1'b1;
        end
        goto_phase(STOP_OK, 8'h00);
        return 1'b0;
    endfunction

    // Advance the sequencer by one slot and return the line levels it drives
    function automatic i2cram_pkg::t_out_item predict_bus_slot(input i2cram_pkg::t_in_item it);
        i2cram_pkg::t_out_item r;
        logic                  scl, sda, req, rvalid, busy, done, ok;
        logic [7:0]            rbyte;
        int unsigned           cnt;
        scl = scl_q;
        sda = sda_q;
        req = 1'b0;
        rbyte = 8'h00;
        rvalid = 1'b0;
        busy = 1'b1;
        done = 1'b0;
        ok = 1'b0;
        if (bus_phase == BUS_IDLE) begin
            if (it.operation == i2cram_pkg::OP_WRITE || it.operation == i2cram_pkg::OP_READ) begin
                dev_addr = it.device_address;
                reg_addr = it.register_address;
                rd_dir = (it.operation == i2cram_pkg::OP_READ);
                cnt = 32'(it.byte_count);
                bytes_remaining = (cnt > BYTE_LIMIT) ? BYTE_LIMIT : cnt;
                goto_phase(BUS_START, 8'h00);
            end else begin
                busy = 1'b0;
            end
        end
        case (bus_phase)
            BUS_IDLE: ;
            BUS_START, BUS_RESTART: begin
                if (slot_cnt == 1) begin
                    scl = 1'b1;
                    sda = 1'b1;
                end else if (slot_cnt == 2) begin
                    sda = 1'b0;
                end
                if (slot_cnt >= 3) begin
                    if (bus_phase == BUS_START) goto_phase(SEND_DEV_W, {dev_addr[7:1], 1'b0});
                    else goto_phase(SEND_DEV_R, {dev_addr[7:1], 1'b1});
                end else begin
                    slot_cnt++;
                end
            end
            SEND_DEV_W, SEND_REG, SEND_DEV_R, SEND_DATA: begin
                // Take the write byte on the first slot of a data byte
                if (bus_phase == SEND_DATA && bit_cnt == 0 && slot_cnt == 0) begin
                    shifter = it.write_byte;
                    if (bytes_remaining > 0) bytes_remaining--;
                end
                if (bit_cnt < 8) begin
                    if (slot_cnt == 0) scl = 1'b0;
                    else if (slot_cnt == 1) sda = shifter[7];
                    else if (slot_cnt == 2) scl = 1'b1;
                    if (slot_cnt >= 3) begin
                        shifter = {shifter[6:0], 1'b0};
                        bit_cnt++;
                        slot_cnt = 0;
                    end else begin
                        slot_cnt++;
                    end
                end else begin
                    // Acknowledge window of the target
                    if (slot_cnt == 0) begin
                        scl = 1'b0;
                        slot_cnt++;
                    end else if (slot_cnt == 1) begin
                        sda = 1'b1;
                        slot_cnt++;
                    end else if (slot_cnt == 2) begin
                        scl = 1'b1;
                        if (it.sda_sample) goto_phase(STOP_FAIL, 8'h00);
                        else slot_cnt++;
                    end else if (slot_cnt == 3) begin
                        slot_cnt++;
                    end else begin
                        scl = 1'b0;
                        req = pick_after_ack();
                    end
                end
            end
            RECV_DATA: begin
                if (bit_cnt < 8) begin
                    if (slot_cnt == 0) begin
                        scl = 1'b0;
                        sda = 1'b1;
                    end else if (slot_cnt == 1) begin
                        scl = 1'b1;
                        shifter = {shifter[6:0], it.sda_sample};
                        if (bit_cnt == 7) begin
                            rvalid = 1'b1;
                            rbyte = shifter;
                        end
                    end else if (slot_cnt == 3) begin
                        scl = 1'b0;
                    end
                    if (slot_cnt >= 3) begin
                        bit_cnt++;
                        slot_cnt = 0;
                    end else begin
                        slot_cnt++;
                    end
                end else begin
                    // Master answers ACK, or NACK on the last byte
                    if (slot_cnt == 0) begin
                        scl = 1'b0;
                        sda = (bytes_remaining <= 1);
                    end else if (slot_cnt == 1) begin
                        scl = 1'b1;
                    end else if (slot_cnt == 3) begin
                        scl = 1'b0;
                    end
                    if (slot_cnt >= 3) begin
                        if (bytes_remaining > 0) bytes_remaining--;
                        if (bytes_remaining > 0) goto_phase(RECV_DATA, 8'h00);
                        else goto_phase(STOP_OK, 8'h00);
                    end else begin
                        slot_cnt++;
                    end
                end
            end
            STOP_OK, STOP_FAIL: begin
                if (slot_cnt == 0) begin
                    scl = 1'b0;
                    sda = 1'b0;
                end else if (slot_cnt == 1) begin
                    scl = 1'b1;
                end else if (slot_cnt == 4) begin
                    sda = 1'b1;
                end
                if (slot_cnt >= 5) begin
                    done = 1'b1;
                    ok = (bus_phase == STOP_OK);
                    goto_phase(BUS_IDLE, 8'h00);
                end else begin
                    slot_cnt++;
                end
            end
            default: begin
                goto_phase(BUS_IDLE, 8'h00);
                busy = 1'b0;
            end
        endcase
        scl_q = scl;
        sda_q = sda;
        r.scl_level = scl;
        r.sda_level = sda;
        r.byte_request = req;
        r.read_byte = rbyte;
        r.read_valid = rvalid;
        r.busy_res = busy;
        r.done_res = done;
        r.success = ok;
        return r;
    endfunction

    // True when the next slot samples the target's acknowledge
    function automatic logic ack_slot_next();
        return (bus_phase == SEND_DEV_W || bus_phase == SEND_REG ||
                bus_phase == SEND_DEV_R || bus_phase == SEND_DATA) &&
               bit_cnt == 8 && slot_cnt == 2;
    endfunction

    // Random slot; write bytes lean toward the extremes
    function automatic i2cram_pkg::t_in_item random_slot();
        i2cram_pkg::t_in_item it;
        it.operation = 2'($urandom_range(3));
        it.device_address = 8'($urandom);
        it.register_address = 8'($urandom);
        it.byte_count = 9'($urandom);
        case ($urandom_range(5))
            0: it.write_byte = 8'h00;
            1: it.write_byte = 8'hFF;
            default: it.write_byte = 8'($urandom);
        endcase
        it.sda_sample = 1'($urandom_range(1));
        return it;
    endfunction

    // Drop valid for a number of cycles
    task automatic feed_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Offer one slot beat, wait for it to be taken, and queue its predicted result
    task automatic send_slot(input i2cram_pkg::t_in_item it);
        i2cram_pkg::t_out_item want;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        want = predict_bus_slot(it);
        slots_due.push_back(want);
        slots_sent++;
        if (want.byte_request) bytes_fed++;
        if (want.read_valid) bytes_read++;
        if (want.done_res && want.success) transfers_ok++;
        if (want.done_res && !want.success) transfers_nacked++;
        if ($urandom_range(99) < feed_idle_pct) feed_gap($urandom_range(1, 4));
    endtask

    // Hold input until every predicted result has come back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (slots_due.size() != 0) @(posedge clk);
    endtask

    // Run one transaction from the idle slot to its last STOP slot; the target
    // answers NACK on the sent byte numbered nack_at (negative: never)
    task automatic run_transfer(input logic [1:0] op, input logic [7:0] dev,
                                input logic [7:0] sub, input logic [8:0] count,
                                input int nack_at, input logic noisy);
        i2cram_pkg::t_in_item it;
        int                   acks;
        acks = 0;
        it = random_slot();
        it.operation = op;
        it.device_address = dev;
        it.register_address = sub;
        it.byte_count = count;
        transfers_started++;
        send_slot(it);
        while (bus_phase != BUS_IDLE) begin
            it = random_slot();
            if (!noisy) it.operation = i2cram_pkg::OP_TICK;
            if (ack_slot_next()) begin
                it.sda_sample = (acks == nack_at);
                acks++;
            end
            send_slot(it);
        end
    endtask

    task automatic test_write_then_read();
        run_transfer(i2cram_pkg::OP_WRITE, 8'h5A, 8'hA5, 9'd1, -1, 1'b0);
        run_transfer(i2cram_pkg::OP_READ, 8'hA5, 8'h5A, 9'd1, -1, 1'b0);
    endtask

    task automatic test_empty_transfers();
        run_transfer(i2cram_pkg::OP_READ, 8'h43, 8'h11, 9'd0, -1, 1'b0);
    endtask

    // NACK on the device address of a write and on the read address of a read
    task automatic test_target_nack();
        run_transfer(i2cram_pkg::OP_WRITE, 8'h20, 8'h01, 9'd2, 0, 1'b0);
        run_transfer(i2cram_pkg::OP_READ, 8'h21, 8'h04, 9'd2, 2, 1'b0);
    endtask

    // Spare code and operations while busy must leave the sequencer alone
    task automatic test_ignored_operations();
        i2cram_pkg::t_in_item it;
        it = random_slot();
        it.operation = OP_SPARE;
        send_slot(it);
        it = random_slot();
        it.operation = i2cram_pkg::OP_TICK;
        send_slot(it);
        run_transfer(i2cram_pkg::OP_WRITE, 8'h7E, 8'hC3, 9'd0, -1, 1'b1);
    endtask

    // Mostly short well-formed transactions, some NACKs, some idle ticks or spare codes
    task automatic test_random_traffic(input int slot_budget);
        i2cram_pkg::t_in_item it;
        int                   stop_at;
        int                   nack_at;
        logic [8:0]           count;
        stop_at = slots_sent + slot_budget;
        while (slots_sent < stop_at) begin
            if ($urandom_range(9) < 2) begin
                it = random_slot();
                it.operation = ($urandom_range(1) != 0) ? i2cram_pkg::OP_TICK : OP_SPARE;
                send_slot(it);
            end else begin
                count = ($urandom_range(9) == 0) ? 9'($urandom_range(3, 12))
                                                 : 9'($urandom_range(0, 2));
                nack_at = ($urandom_range(4) == 0) ? int'($urandom_range(0, 32'(count) + 2))
                                                   : -1;
                run_transfer(($urandom_range(1) != 0) ? i2cram_pkg::OP_WRITE
                                                      : i2cram_pkg::OP_READ,
                             8'($urandom), 8'($urandom), count, nack_at, 1'b1);
            end
        end
    endtask

    // Stall the result side at random
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= drain_idle_pct);
    end

    // Count cycles without any beat on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    task automatic report_mismatch(input logic have_want, input i2cram_pkg::t_out_item want,
                                   input i2cram_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10) begin
            if (have_want) begin
                $write("%0t: result %0d expected scl=%b sda=%b req=%b rbyte=%h rvalid=%b",
                       $time, results_seen, want.scl_level, want.sda_level,
                       want.byte_request, want.read_byte, want.read_valid);
                $display(" busy=%b done=%b ok=%b", want.busy_res, want.done_res,
                         want.success);
            end else begin
                $display("%0t: result %0d arrived with nothing expected", $time,
                         results_seen);
            end
            $display("    got scl=%b sda=%b req=%b rbyte=%h rvalid=%b busy=%b done=%b ok=%b",
                     got.scl_level, got.sda_level, got.byte_request, got.read_byte,
                     got.read_valid, got.busy_res, got.done_res, got.success);
        end
    endtask

    // Compare each result beat with the oldest prediction
    always @(posedge clk) begin : check_results
        i2cram_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (slots_due.size() == 0) begin
                want = '0;
                report_mismatch(1'b0, want, out_item);
            end else begin
                want = slots_due.pop_front();
                if (out_item.scl_level !== want.scl_level ||
                    out_item.sda_level !== want.sda_level ||
                    out_item.byte_request !== want.byte_request ||
                    out_item.read_byte !== want.read_byte ||
                    out_item.read_valid !== want.read_valid ||
                    out_item.busy_res !== want.busy_res ||
                    out_item.done_res !== want.done_res ||
                    out_item.success !== want.success)
                    report_mismatch(1'b1, want, out_item);
            end
            results_seen++;
        end
    end

    // End the run when the block stops moving
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under light sender and heavy receiver idling
        feed_idle_pct = 14;
        drain_idle_pct = 67;
        test_write_then_read();
        test_empty_transfers();
        test_target_nack();
        test_ignored_operations();
        wait_all_results();

        feed_idle_pct = 67;
        drain_idle_pct = 14;
        test_random_traffic(40);

        feed_idle_pct = 0;
        drain_idle_pct = 0;
        test_random_traffic(40);

        // Drain and let any stray beat show up
        wait_all_results();
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d slots in %0d transactions: %0d completed, %0d ended on NACK",
                 slots_sent, transfers_started, transfers_ok, transfers_nacked);
        $display("%0d write bytes requested, %0d bytes received, %0d mismatches",
                 bytes_fed, bytes_read, mismatches);
        if (mismatches == 0 && slots_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
